FILE: design/sm83b_pkg.sv
// shared types and constants of the sm83 branch unit
package sm83b_pkg;

    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned EXTRA_W = 4;

    localparam logic [7:0] OP_JP_NN   = 8'hC3;
    localparam logic [7:0] OP_JR      = 8'h18;
    localparam logic [7:0] OP_JP_HL   = 8'hE9;
    localparam logic [7:0] OP_CALL_NN = 8'hCD;
    localparam logic [7:0] OP_RET     = 8'hC9;
    localparam logic [7:0] OP_RETI    = 8'hD9;

    localparam logic [7:0] MASK_CC    = 8'hE7;
    localparam logic [7:0] OP_JP_CC   = 8'hC2;
    localparam logic [7:0] OP_JR_CC   = 8'h20;
    localparam logic [7:0] OP_CALL_CC = 8'hC4;
    localparam logic [7:0] OP_RET_CC  = 8'hC0;
    localparam logic [7:0] MASK_RST   = 8'hC7;
    localparam logic [7:0] OP_RST     = 8'hC7;
    localparam logic [7:0] RST_VECTOR = 8'h38;

    localparam logic [1:0] CC_NZ = 2'd0;
    localparam logic [1:0] CC_Z  = 2'd1;
    localparam logic [1:0] CC_NC = 2'd2;
    localparam logic [1:0] CC_C  = 2'd3;

    localparam logic [ADDR_W-1:0] LEN_1 = 16'd1;
    localparam logic [ADDR_W-1:0] LEN_2 = 16'd2;
    localparam logic [ADDR_W-1:0] LEN_3 = 16'd3;
    localparam logic [ADDR_W-1:0] SP_STEP = 16'd2;

    localparam logic [EXTRA_W-1:0] EXTRA_JUMP = 4'd4;
    localparam logic [EXTRA_W-1:0] EXTRA_CALL = 4'd12;

    typedef struct packed {
        logic [7:0]        opcode;
        logic [7:0]        imm_lo;
        logic [7:0]        imm_hi;
        logic              flag_zero;
        logic              flag_carry;
        logic [ADDR_W-1:0] hl_value;
        logic [ADDR_W-1:0] stack_word;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]  next_pc;
        logic [ADDR_W-1:0]  new_sp;
        logic               push_valid;
        logic [ADDR_W-1:0]  push_address;
        logic [ADDR_W-1:0]  push_word;
        logic               branch_taken;
        logic [EXTRA_W-1:0] extra_cycles;
        logic               ime_set;
        logic               recognized;
    } t_out_item;

endpackage

FILE: design/sm83b_if.sv
// valid/ready channel interfaces for instruction items and results
interface sm83b_in_if
    import sm83b_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sm83b_out_if
    import sm83b_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/sm83b_in_reg.sv
// input register stage holding one instruction item
module sm83b_in_reg
    import sm83b_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sm83b_in_if.sink    i_in,
    input  logic        i_advance,
    output logic        o_valid,
    output t_in_item    o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     n_valid;

    assign i_in.ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (i_in.ready) begin
            n_valid = i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= i_in.payload;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: design/sm83b_exec.sv
// decode and execute of one control-flow instruction against pc and sp
module sm83b_exec
    import sm83b_pkg::*;
(
    input  t_in_item          i_item,
    input  logic [ADDR_W-1:0] i_pc,
    input  logic [ADDR_W-1:0] i_sp,
    output t_out_item         o_result
);

    logic [7:0]        op;
    logic              cond;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] rel;
    logic [ADDR_W-1:0] pc_p1;
    logic [ADDR_W-1:0] pc_p2;
    logic [ADDR_W-1:0] pc_p3;
    logic [ADDR_W-1:0] pc_jr;
    logic [ADDR_W-1:0] sp_dn;
    logic [ADDR_W-1:0] sp_up;

    assign op     = i_item.opcode;
    assign target = {i_item.imm_hi, i_item.imm_lo};
    assign rel    = {{8{i_item.imm_lo[7]}}, i_item.imm_lo};
    assign pc_p1  = i_pc + LEN_1;
    assign pc_p2  = i_pc + LEN_2;
    assign pc_p3  = i_pc + LEN_3;
    assign pc_jr  = pc_p2 + rel;
    assign sp_dn  = i_sp - SP_STEP;
    assign sp_up  = i_sp + SP_STEP;

    always_comb begin
        case (op[4:3])
            CC_NZ:   cond = !i_item.flag_zero;
            CC_Z:    cond = i_item.flag_zero;
            CC_NC:   cond = !i_item.flag_carry;
            CC_C:    cond = i_item.flag_carry;
            default: cond = 1'b0;
        endcase
    end

    always_comb begin
        o_result              = '0;
        o_result.next_pc      = i_pc;
        o_result.new_sp       = i_sp;
        o_result.recognized   = 1'b1;
        if (op == OP_JP_NN) begin
            o_result.next_pc      = target;
            o_result.branch_taken = 1'b1;
        end else if ((op & MASK_CC) == OP_JP_CC) begin
            if (cond) begin
                o_result.next_pc      = target;
                o_result.branch_taken = 1'b1;
                o_result.extra_cycles = EXTRA_JUMP;
            end else begin
                o_result.next_pc = pc_p3;
            end
        end else if (op == OP_JR) begin
            o_result.next_pc      = pc_jr;
            o_result.branch_taken = 1'b1;
        end else if ((op & MASK_CC) == OP_JR_CC) begin
            if (cond) begin
                o_result.next_pc      = pc_jr;
                o_result.branch_taken = 1'b1;
                o_result.extra_cycles = EXTRA_JUMP;
            end else begin
                o_result.next_pc = pc_p2;
            end
        end else if (op == OP_JP_HL) begin
            o_result.next_pc      = i_item.hl_value;
            o_result.branch_taken = 1'b1;
        end else if (op == OP_CALL_NN) begin
            o_result.next_pc      = target;
            o_result.new_sp       = sp_dn;
            o_result.push_valid   = 1'b1;
            o_result.push_address = sp_dn;
            o_result.push_word    = pc_p3;
            o_result.branch_taken = 1'b1;
        end else if ((op & MASK_CC) == OP_CALL_CC) begin
            if (cond) begin
                o_result.next_pc      = target;
                o_result.new_sp       = sp_dn;
                o_result.push_valid   = 1'b1;
                o_result.push_address = sp_dn;
                o_result.push_word    = pc_p3;
                o_result.branch_taken = 1'b1;
                o_result.extra_cycles = EXTRA_CALL;
            end else begin
                o_result.next_pc = pc_p3;
            end
        end else if (op == OP_RET) begin
            o_result.next_pc      = i_item.stack_word;
            o_result.new_sp       = sp_up;
            o_result.branch_taken = 1'b1;
        end else if ((op & MASK_CC) == OP_RET_CC) begin
            if (cond) begin
                o_result.next_pc      = i_item.stack_word;
                o_result.new_sp       = sp_up;
                o_result.branch_taken = 1'b1;
                o_result.extra_cycles = EXTRA_CALL;
            end else begin
                o_result.next_pc = pc_p1;
            end
        end else if (op == OP_RETI) begin
            // ime ends up set after every reti, so the flag itself is just ime_set
            o_result.next_pc      = i_item.stack_word;
            o_result.new_sp       = sp_up;
            o_result.branch_taken = 1'b1;
            o_result.ime_set      = 1'b1;
        end else if ((op & MASK_RST) == OP_RST) begin
            o_result.next_pc      = {8'h00, op & RST_VECTOR};
            o_result.new_sp       = sp_dn;
            o_result.push_valid   = 1'b1;
            o_result.push_address = sp_dn;
            o_result.push_word    = pc_p1;
            o_result.branch_taken = 1'b1;
        end else begin
            o_result.recognized = 1'b0;
        end
    end

endmodule

FILE: design/sm83_branch_unit.sv
// top level of the sm83 branch unit: input stage, execute, pc/sp state, result register
//
//  channel | port  | dir | carries
//  --------+-------+-----+------------------------------------------
//  in      | i_in  | in  | opcode, immediates, z/c flags, hl, stack word
//  out     | o_out | out | next pc, new sp, push request, taken, extra cycles
//
// one instruction per cycle while the output is not stalled; each passes the input register, then the result register
// pc and sp update when an item moves from the input register into the result register
// the pc/sp feedback through the execute adders sets the rate
// reset clears pc and sp to zero and empties both stages
// a stalled output holds its result and backs the input stage up by one item
module sm83_branch_unit
    import sm83b_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    sm83b_in_if.sink   i_in,
    sm83b_out_if.source o_out
);

    logic              advance;
    logic              stage_valid;
    t_in_item          stage_item;
    t_out_item         exec_result;

    logic [ADDR_W-1:0] r_pc;
    logic [ADDR_W-1:0] r_sp;
    logic              r_out_valid;
    t_out_item         r_out;
    logic              n_out_valid;

    assign advance = !r_out_valid || o_out.ready;

    sm83b_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    sm83b_exec u_exec (
        .i_item   (stage_item),
        .i_pc     (r_pc),
        .i_sp     (r_sp),
        .o_result (exec_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = stage_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_sp        <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (advance && stage_valid) begin
                r_pc <= exec_result.next_pc;
                r_sp <= exec_result.new_sp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && stage_valid) begin
            r_out <= exec_result;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule
